// ===== src/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg
// Shared constants, register codes, pipeline stage type and arithmetic helpers
// for the environmental sensor compensation pipeline.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned NumStages       = 35;
  localparam int unsigned DivFirst        = 13;
  localparam int unsigned DivStages       = 16;
  localparam int unsigned DivBitsPerStage = 4;

  localparam int unsigned PaddrWidth = 6;
  localparam int unsigned PdataWidth = 64;

  localparam int unsigned RawTempWidth  = 20;
  localparam int unsigned RawPressWidth = 20;
  localparam int unsigned RawHumWidth   = 16;
  localparam int unsigned TempWidth     = 32;
  localparam int unsigned PressWidth    = 32;
  localparam int unsigned HumWidth      = 17;

  localparam logic [33:0] FineOffset    = 34'd128000;
  localparam logic [63:0] PressRef      = 64'd1048576;
  localparam logic [63:0] PressScale    = 64'd3125;
  localparam logic [63:0] PressBias     = 64'h0000_8000_0000_0000;
  localparam logic [31:0] HumFineOffset = 32'd76800;
  localparam logic [31:0] HumRound14    = 32'd16384;
  localparam logic [31:0] HumBias15     = 32'd32768;
  localparam logic [31:0] HumBias21     = 32'd2097152;
  localparam logic [31:0] HumRound13    = 32'd8192;
  localparam logic [31:0] HumMax        = 32'd419430400;

  typedef enum logic [2:0] {
    REG_TEMP_CALIB  = 3'd0,
    REG_PRESS_LOW   = 3'd1,
    REG_PRESS_MID   = 3'd2,
    REG_PRESS_LAST  = 3'd3,
    REG_HUM_CALIB   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [RawTempWidth-1:0]  adc_t;
    logic [RawPressWidth-1:0] adc_p;
    logic [RawHumWidth-1:0]   adc_h;
    logic [31:0] ta;
    logic [31:0] tdd;
    logic [31:0] ta_s;
    logic [31:0] tdb;
    logic [31:0] fine;
    logic [TempWidth-1:0] temp;
    logic [33:0] x;
    logic [31:0] hvo;
    logic [63:0] xx;
    logic [63:0] xp5;
    logic [63:0] xp2;
    logic [31:0] h5v;
    logic [31:0] hb1;
    logic [31:0] hc1;
    logic [31:0] ha;
    logic [31:0] hbb;
    logic [31:0] hb2;
    logic [63:0] y1;
    logic [63:0] x3;
    logic [63:0] y;
    logic [63:0] xs;
    logic [31:0] hv;
    logic [63:0] m;
    logic [31:0] hd2;
    logic [30:0] dv;
    logic [63:0] nn;
    logic [31:0] he;
    logic [63:0] num;
    logic        dzero;
    logic [HumWidth-1:0] hum;
    logic [63:0] dq;
    logic [31:0] dr;
    logic [30:0] dden;
    logic        qneg;
    logic [63:0] pr;
    logic [63:0] p9s;
    logic [63:0] p8pr;
    logic [63:0] pp0;
    logic [31:0] pp1;
    logic [31:0] pp2;
    logic [63:0] xq;
    logic [63:0] sum;
    logic [PressWidth-1:0] press;
  } esc_stage_t;

  function automatic logic [31:0] sra32(input logic [31:0] x, input int unsigned s);
    return 32'($signed(x) >>> s);
  endfunction

  function automatic logic [63:0] sra64(input logic [63:0] x, input int unsigned s);
    return 64'($signed(x) >>> s);
  endfunction

endpackage

// ===== src/esc_if.sv =====
// ----------------------------------------------------------------------------
// esc_if
// Valid/ready channels for raw readings and compensated results.
// ----------------------------------------------------------------------------
interface esc_in_if;
  logic                                valid;
  logic                                ready;
  logic [esc_pkg::RawTempWidth-1:0]    raw_temp;
  logic [esc_pkg::RawPressWidth-1:0]   raw_press;
  logic [esc_pkg::RawHumWidth-1:0]     raw_hum;

  modport source (output valid, output raw_temp, output raw_press, output raw_hum,
                  input ready);
  modport sink (input valid, input raw_temp, input raw_press, input raw_hum,
                output ready);
endinterface

interface esc_out_if;
  logic                             valid;
  logic                             ready;
  logic [esc_pkg::TempWidth-1:0]    temp_centi;
  logic [esc_pkg::PressWidth-1:0]   press_q24_8;
  logic [esc_pkg::HumWidth-1:0]     hum_q22_10;

  modport source (output valid, output temp_centi, output press_q24_8,
                  output hum_q22_10, input ready);
  modport sink (input valid, input temp_centi, input press_q24_8, input hum_q22_10,
                output ready);
endinterface

// ===== src/env_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// env_sensor_compensation
// Throughput: one item per cycle; the whole pipe holds while the result stalls.
// The 64-bit pressure divide runs as 16 stages of 4 restoring steps each.
// Reset clears valid bits and calibration registers; data registers are not reset.
// ----------------------------------------------------------------------------
module env_sensor_compensation (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  esc_in_if.sink                             in_i,
  esc_out_if.source                          out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [esc_pkg::PaddrWidth-1:0]     paddr,
  input  logic [esc_pkg::PdataWidth-1:0]     pwdata,
  output logic [esc_pkg::PdataWidth-1:0]     prdata,
  output logic                               pready
);

  localparam int unsigned Last = esc_pkg::NumStages - 1;

  logic [47:0] temp_calib_q;
  logic [63:0] press_low_q;
  logic [63:0] press_mid_q;
  logic [15:0] press_last_q;
  logic [63:0] hum_calib_q;

  esc_pkg::reg_idx_e reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = esc_pkg::reg_idx_e'(paddr[esc_pkg::PaddrWidth-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_calib_q <= '0;
      press_low_q  <= '0;
      press_mid_q  <= '0;
      press_last_q <= '0;
      hum_calib_q  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        esc_pkg::REG_TEMP_CALIB: temp_calib_q <= pwdata[47:0];
        esc_pkg::REG_PRESS_LOW:  press_low_q  <= pwdata;
        esc_pkg::REG_PRESS_MID:  press_mid_q  <= pwdata;
        esc_pkg::REG_PRESS_LAST: press_last_q <= pwdata[15:0];
        esc_pkg::REG_HUM_CALIB:  hum_calib_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      esc_pkg::REG_TEMP_CALIB: prdata = {16'b0, temp_calib_q};
      esc_pkg::REG_PRESS_LOW:  prdata = press_low_q;
      esc_pkg::REG_PRESS_MID:  prdata = press_mid_q;
      esc_pkg::REG_PRESS_LAST: prdata = {48'b0, press_last_q};
      esc_pkg::REG_HUM_CALIB:  prdata = hum_calib_q;
      default:                 prdata = '0;
    endcase
  end

  logic        [15:0] t1;
  logic signed [15:0] t2, t3;
  logic        [15:0] p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
  logic        [7:0]  h1, h3;
  logic signed [15:0] h2;
  logic signed [11:0] h4, h5;
  logic signed [7:0]  h6;

  assign t1 = temp_calib_q[15:0];
  assign t2 = temp_calib_q[31:16];
  assign t3 = temp_calib_q[47:32];
  assign p1 = press_low_q[15:0];
  assign p2 = press_low_q[31:16];
  assign p3 = press_low_q[47:32];
  assign p4 = press_low_q[63:48];
  assign p5 = press_mid_q[15:0];
  assign p6 = press_mid_q[31:16];
  assign p7 = press_mid_q[47:32];
  assign p8 = press_mid_q[63:48];
  assign p9 = press_last_q;
  assign h1 = hum_calib_q[7:0];
  assign h2 = hum_calib_q[23:8];
  assign h3 = hum_calib_q[31:24];
  assign h4 = hum_calib_q[43:32];
  assign h5 = hum_calib_q[55:44];
  assign h6 = hum_calib_q[63:56];

  esc_pkg::esc_stage_t st_q [esc_pkg::NumStages];
  esc_pkg::esc_stage_t st_d [esc_pkg::NumStages];
  logic [esc_pkg::NumStages-1:0] vld_q;
  logic                          adv;

  assign adv         = ~vld_q[Last] | out_o.ready;
  assign in_i.ready  = adv;

  always_comb begin
    logic signed [17:0] d1;
    logic signed [16:0] d2;
    logic [63:0] mw;
    logic [63:0] sv;
    logic [31:0] hv2;
    logic [31:0] hcl;
    logic [31:0] r;
    logic [31:0] t;
    logic [63:0] q;
    logic        ge;

    st_d[0]       = st_q[0];
    st_d[0].adc_t = in_i.raw_temp;
    st_d[0].adc_p = in_i.raw_press;
    st_d[0].adc_h = in_i.raw_hum;

    st_d[1]     = st_q[0];
    d1          = $signed({1'b0, st_q[0].adc_t[19:3]}) - $signed({1'b0, t1, 1'b0});
    d2          = $signed({1'b0, st_q[0].adc_t[19:4]}) - $signed({1'b0, t1});
    st_d[1].ta  = 32'(d1 * t2);
    st_d[1].tdd = 32'(d2 * d2);

    st_d[2]      = st_q[1];
    st_d[2].ta_s = esc_pkg::sra32(st_q[1].ta, 11);
    st_d[2].tdb  = 32'($signed(esc_pkg::sra32(st_q[1].tdd, 12)) * t3);

    st_d[3]      = st_q[2];
    st_d[3].fine = st_q[2].ta_s + esc_pkg::sra32(st_q[2].tdb, 14);

    st_d[4]      = st_q[3];
    st_d[4].temp = esc_pkg::sra32(st_q[3].fine * 32'd5 + 32'd128, 8);
    st_d[4].x    = {{2{st_q[3].fine[31]}}, st_q[3].fine} - esc_pkg::FineOffset;
    st_d[4].hvo  = st_q[3].fine - esc_pkg::HumFineOffset;

    st_d[5]     = st_q[4];
    st_d[5].xx  = 64'($signed(st_q[4].x) * $signed(st_q[4].x));
    st_d[5].xp5 = 64'($signed(st_q[4].x) * p5);
    st_d[5].xp2 = 64'($signed(st_q[4].x) * p2);
    st_d[5].h5v = 32'($signed(st_q[4].hvo) * h5);
    st_d[5].hb1 = 32'($signed(st_q[4].hvo) * h6);
    st_d[5].hc1 = st_q[4].hvo * 32'(h3);

    st_d[6]     = st_q[5];
    st_d[6].ha  = esc_pkg::sra32(({16'b0, st_q[5].adc_h} << 14) - (32'(h4) << 20)
                                 - st_q[5].h5v + esc_pkg::HumRound14, 15);
    st_d[6].hbb = esc_pkg::sra32(st_q[5].hb1, 10)
                  * (esc_pkg::sra32(st_q[5].hc1, 11) + esc_pkg::HumBias15);

    st_d[7]     = st_q[6];
    st_d[7].y1  = st_q[6].xx * 64'(p6);
    st_d[7].x3  = st_q[6].xx * 64'(p3);
    st_d[7].hb2 = (esc_pkg::sra32(st_q[6].hbb, 10) + esc_pkg::HumBias21) * 32'(h2)
                  + esc_pkg::HumRound13;

    st_d[8]    = st_q[7];
    st_d[8].y  = st_q[7].y1 + (st_q[7].xp5 << 17) + (64'(p4) << 35);
    st_d[8].xs = esc_pkg::sra64(st_q[7].x3, 8) + (st_q[7].xp2 << 12);
    st_d[8].hv = st_q[7].ha * esc_pkg::sra32(st_q[7].hb2, 14);

    st_d[9]     = st_q[8];
    st_d[9].m   = (esc_pkg::PressBias + st_q[8].xs) * 64'(p1);
    st_d[9].hd2 = esc_pkg::sra32(st_q[8].hv, 15) * esc_pkg::sra32(st_q[8].hv, 15);

    st_d[10]    = st_q[9];
    mw          = esc_pkg::sra64(st_q[9].m, 33);
    st_d[10].dv = mw[30:0];
    st_d[10].nn = ((esc_pkg::PressRef - 64'(st_q[9].adc_p)) << 31) - st_q[9].y;
    st_d[10].he = esc_pkg::sra32(st_q[9].hd2, 7) * 32'(h1);

    st_d[11]       = st_q[10];
    st_d[11].num   = st_q[10].nn * esc_pkg::PressScale;
    st_d[11].dzero = (st_q[10].dv == '0);
    hv2            = st_q[10].hv - esc_pkg::sra32(st_q[10].he, 4);
    if (hv2[31]) begin
      hcl = '0;
    end else if (hv2 > esc_pkg::HumMax) begin
      hcl = esc_pkg::HumMax;
    end else begin
      hcl = hv2;
    end
    st_d[11].hum = hcl[28:12];

    st_d[12]      = st_q[11];
    st_d[12].dq   = st_q[11].num[63] ? (~st_q[11].num + 64'd1) : st_q[11].num;
    st_d[12].dden = st_q[11].dv[30] ? (~st_q[11].dv + 31'd1) : st_q[11].dv;
    st_d[12].dr   = '0;
    st_d[12].qneg = st_q[11].num[63] ^ st_q[11].dv[30];

    for (int unsigned g = 0; g < esc_pkg::DivStages; g++) begin
      st_d[esc_pkg::DivFirst + g] = st_q[esc_pkg::DivFirst + g - 1];
      r = st_q[esc_pkg::DivFirst + g - 1].dr;
      q = st_q[esc_pkg::DivFirst + g - 1].dq;
      for (int unsigned j = 0; j < esc_pkg::DivBitsPerStage; j++) begin
        t  = {r[30:0], q[63]};
        ge = (t >= {1'b0, st_q[esc_pkg::DivFirst + g - 1].dden});
        r  = ge ? (t - {1'b0, st_q[esc_pkg::DivFirst + g - 1].dden}) : t;
        q  = {q[62:0], ge};
      end
      st_d[esc_pkg::DivFirst + g].dr = r;
      st_d[esc_pkg::DivFirst + g].dq = q;
    end

    st_d[29]    = st_q[28];
    st_d[29].pr = st_q[28].qneg ? (~st_q[28].dq + 64'd1) : st_q[28].dq;

    st_d[30]      = st_q[29];
    st_d[30].p9s  = esc_pkg::sra64(st_q[29].pr, 13) * 64'(p9);
    st_d[30].p8pr = st_q[29].pr * 64'(p8);

    st_d[31]     = st_q[30];
    sv           = esc_pkg::sra64(st_q[30].pr, 13);
    st_d[31].pp0 = 64'(st_q[30].p9s[31:0]) * 64'(sv[31:0]);
    st_d[31].pp1 = st_q[30].p9s[31:0] * sv[63:32];
    st_d[31].pp2 = st_q[30].p9s[63:32] * sv[31:0];

    st_d[32]    = st_q[31];
    st_d[32].xq = st_q[31].pp0 + {st_q[31].pp1 + st_q[31].pp2, 32'b0};

    st_d[33]     = st_q[32];
    st_d[33].sum = st_q[32].pr + esc_pkg::sra64(st_q[32].xq, 25)
                   + esc_pkg::sra64(st_q[32].p8pr, 19);

    st_d[34]       = st_q[33];
    st_d[34].press = st_q[33].dzero ? '0
                     : 32'(esc_pkg::sra64(st_q[33].sum, 8) + (64'(p7) << 4));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Last-1:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q <= st_d;
    end
  end

  assign out_o.valid       = vld_q[Last];
  assign out_o.temp_centi  = st_q[Last].temp;
  assign out_o.press_q24_8 = st_q[Last].press;
  assign out_o.hum_q22_10  = st_q[Last].hum;

  a_valid_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> vld_q[1] == $past(vld_q[0]))
    else $error("valid bit lost between first stages");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> vld_q == $past(vld_q))
    else $error("pipe moved while result stalled");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[esc_pkg::DivFirst + esc_pkg::DivStages - 1]
      && !st_q[esc_pkg::DivFirst + esc_pkg::DivStages - 1].dzero
    |-> st_q[esc_pkg::DivFirst + esc_pkg::DivStages - 1].dr
        < {1'b0, st_q[esc_pkg::DivFirst + esc_pkg::DivStages - 1].dden})
    else $error("divider remainder not below divisor");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.hum_q22_10 <= 17'd102400)
    else $error("humidity above clamp");

endmodule
